@@ hw/rtl/sl_pkg.sv @@
// Package with the shared types and constants of the sorted list insert/delete block.
package sl_pkg;

  // Number of cells in the sorted table.
  localparam int unsigned DEPTH = 16;
  // Width of the internal entry count, which must hold DEPTH itself.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Width of the entry count result field.
  localparam int unsigned COUNT_OUT_W = 5;
  // Width of one stored key.
  localparam int unsigned KEY_W = 32;

  // Action codes of an input item.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // Status codes of a result item.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] value;
  } sl_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [COUNT_OUT_W-1:0]  entry_count;
    logic signed [KEY_W-1:0] smallest;
  } sl_out_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                    ins_en;
    logic                    del_en;
    logic signed [KEY_W-1:0] key;
  } sl_cmd_t;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic signed [KEY_W-1:0] entry;
    logic                    ins_after;
    logic                    del_after;
  } sl_link_t;

endpackage

@@ hw/rtl/sorted_list_insert_delete.sv @@
// Top level of the sorted list insert/delete block: a chain of key cells and the result register.
//
//   channel  direction  payload   accepted when
//   in       input      sl_in_t   in_valid_i  && !in_stall_o
//   out      output     sl_out_t  out_valid_o && !out_stall_i
//
// In every operation the key is broadcast to all cells, each cell compares it
// with its own entry; cells from the insert or delete point on shift one place in the same edge.
// One operation can be accepted in every cycle while the result register drains.
// The result is registered and appears in the cycle after its operation is accepted.
// Reset empties the table by clearing the entry count; the cells themselves keep no reset.
// While a result waits under out_stall_i, the input channel is stalled too.
module sorted_list_insert_delete (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sl_pkg::sl_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sl_pkg::sl_out_t out_data_o
);
  import sl_pkg::*;

  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  sl_out_t                 out_data_q, out_data_d;
  logic                    accept, full, found;
  sl_cmd_t                 cmd;
  sl_link_t                links    [DEPTH];
  logic signed [KEY_W-1:0] nexts    [DEPTH];
  logic [DEPTH-1:0]        hits;
  logic [31:0]             count_ext;

  // A new operation can enter whenever the result register is empty or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CNT_W'(DEPTH));
  // At most one cell reports a hit, so a reduction OR finds it.
  assign found = |hits;

  assign cmd.ins_en = accept && (in_data_i.action == ACT_INSERT) && !full;
  assign cmd.del_en = accept && (in_data_i.action == ACT_DELETE) && found;
  assign cmd.key    = in_data_i.value;

  // The row of cells. A cell is occupied when its position lies below the entry count.
  // Inserts shift entries toward the tail, deletes pull them toward the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sl_link_t                left;
    logic signed [KEY_W-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left = '{entry: '0, ins_after: 1'b0, del_after: 1'b0};
    end else begin : g_mid
      assign left = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = links[i+1].entry;
    end

    sl_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (CNT_W'(i) < count_q),
      .left_i        (left),
      .right_entry_i (right_entry),
      .link_o        (links[i]),
      .next_o        (nexts[i]),
      .hit_o         (hits[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.del_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign count_ext = 32'(count_d);

  always_comb begin
    out_data_d.status = ST_DONE;
    if (in_data_i.action == ACT_INSERT) begin
      if (full) begin
        out_data_d.status = ST_FULL;
      end
    end else if (!found) begin
      out_data_d.status = ST_NOT_FOUND;
    end
    out_data_d.entry_count = count_ext[COUNT_OUT_W-1:0];
    // The head cell's next value is the smallest entry after this operation.
    out_data_d.smallest    = (count_d != '0) ? nexts[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  // An insert into a full table is rejected and leaves the count alone.
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.action == ACT_INSERT) && full)
    |=> (out_data_o.status == ST_FULL) && (count_q == CNT_W'(DEPTH)))
    else $error("insert into full table not rejected");

  // Every accepted operation produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted operation produced no result");

  // A failed delete leaves the entry count unchanged.
  a_miss_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.action == ACT_DELETE) && !found) |=> (count_q == $past(count_q)))
    else $error("delete miss changed the entry count");

endmodule

@@ hw/rtl/sl_cell.sv @@
// One cell of the sorted table: holds one key and shifts it toward either neighbor.
module sl_cell (
  input  logic                          clk_i,
  input  sl_pkg::sl_cmd_t               cmd_i,
  input  logic                          occ_i,
  input  sl_pkg::sl_link_t              left_i,
  input  logic signed [sl_pkg::KEY_W-1:0] right_entry_i,
  output sl_pkg::sl_link_t              link_o,
  output logic signed [sl_pkg::KEY_W-1:0] next_o,
  output logic                          hit_o
);
  import sl_pkg::*;

  logic signed [KEY_W-1:0] entry_q, entry_d;
  logic                    ins_after, del_after;

  // The insert point lies at or before this cell when it is empty or holds a larger key.
  assign ins_after = !(occ_i && (entry_q <= cmd_i.key));
  // The delete point lies at or before this cell when it is empty or holds a key not smaller.
  assign del_after = !(occ_i && (entry_q < cmd_i.key));
  // This is the first cell not below the key, and it holds the key itself.
  assign hit_o = del_after && !left_i.del_after && occ_i && (entry_q == cmd_i.key);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en && ins_after) begin
      entry_d = left_i.ins_after ? left_i.entry : cmd_i.key;
    end else if (cmd_i.del_en && del_after) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o = '{entry: entry_q, ins_after: ins_after, del_after: del_after};
  assign next_o = entry_d;

endmodule
